FILE: design/bfg_pkg.sv
// ----------------------------------------------------------------------------
// bfg_pkg
// shared constants, codes and payload types of the bit fifo byte gearbox
// ----------------------------------------------------------------------------
package bfg_pkg;

    // store depth in bits, a power of two from 16 to 1024
    localparam int DEPTH_BITS = 1024;
    localparam int POS_W      = $clog2(DEPTH_BITS);
    localparam int CNT_W      = POS_W + 1;
    localparam int LANES      = 8;
    localparam int LANE_W     = 3;
    localparam int ROW_W      = POS_W - LANE_W;
    localparam int ROWS       = DEPTH_BITS / LANES;
    localparam int HELD_W     = 11;
    localparam int TAKE_W     = 4;

    typedef enum logic [2:0] {
        MODE_PUSH_BIT  = 3'd0,
        MODE_PUSH_BYTE = 3'd1,
        MODE_POP_BIT   = 3'd2,
        MODE_POP_BYTE  = 3'd3,
        MODE_CLEAR     = 3'd4
    } t_mode;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_GATHER
    } t_state;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] data_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0]        data_out;
        logic [HELD_W-1:0] bits_held;
        logic              overflow;
        logic              underrun;
    } t_out_item;

    // what the gather step needs to know about a pop in flight
    typedef struct packed {
        logic [LANE_W-1:0] offset;
        logic [TAKE_W-1:0] taken;
        logic              msb_first;
        logic              is_byte;
        logic              underrun;
    } t_pop_ctx;

endpackage

FILE: design/bit_fifo_byte_gearbox_core.sv
// ----------------------------------------------------------------------------
// bit_fifo_byte_gearbox_core
// bit fifo with byte serializer and deserializer over eight interleaved banks
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  ---------------------------
//  in       input      i_in_valid / o_in_ready   i_in_data  (t_in_item)
//  out      output     o_out_valid / i_out_ready o_out_data (t_out_item)
//  cfg      input      i_cfg_valid / o_cfg_ready i_cfg_data (msb_first)
//
//  push bit, push byte, clear and unused modes load the result register on acceptance
//  pop bit and pop byte read the banks into registers, then the gather state loads the result
//  bit position p lives in bank p mod 8, row p / 8, so any 8 consecutive bits
//  touch each bank once and a byte moves in a single memory access
//  synchronous active-low reset zeroes the positions and count, no clearing
//  pass; the banks hold garbage until written and are never read before that
//  a new transfer is taken in the idle state while the result register is empty or draining
//
module bit_fifo_byte_gearbox_core
    import bfg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_data
);

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH_BITS);

    // control state
    t_state           r_state, n_state;
    logic [POS_W-1:0] r_wp, n_wp;
    logic [POS_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_msb;
    logic             r_out_valid;

    // payload
    t_out_item        r_out, n_out;
    t_pop_ctx         r_ctx, n_ctx;

    // handshake and fsm outputs
    logic             w_accept;
    logic             w_load_gather;

    // per-item decode
    logic             w_is_push, w_is_pop, w_is_byte;
    logic [TAKE_W-1:0] w_req;
    logic [CNT_W-1:0] w_room;
    logic [TAKE_W-1:0] w_n_push;
    logic [TAKE_W-1:0] w_taken;
    logic [LANES-1:0] w_ser;

    // bank ports
    logic [ROW_W-1:0] w_addr [LANES];
    logic [LANES-1:0] w_we;
    logic [LANES-1:0] w_wdata;
    logic [LANES-1:0] w_rdata;
    logic [7:0]       w_gather;

    // config register is always writable
    assign o_cfg_ready = 1'b1;

    assign w_accept = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // fsm: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && w_is_pop) begin
                    n_state = ST_GATHER;
                end
            end
            ST_GATHER: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // fsm: outputs
    // ------------------------------------------------------------------
    always_comb begin
        o_in_ready    = 1'b0;
        w_load_gather = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = !r_out_valid || i_out_ready;
            end
            ST_GATHER: begin
                w_load_gather = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // decode: how many bits move
    // ------------------------------------------------------------------
    always_comb begin
        w_is_push = 1'b0;
        w_is_pop  = 1'b0;
        w_is_byte = 1'b0;
        unique case (i_in_data.mode)
            MODE_PUSH_BIT:  w_is_push = 1'b1;
            MODE_PUSH_BYTE: begin
                w_is_push = 1'b1;
                w_is_byte = 1'b1;
            end
            MODE_POP_BIT:   w_is_pop = 1'b1;
            MODE_POP_BYTE:  begin
                w_is_pop  = 1'b1;
                w_is_byte = 1'b1;
            end
            default: begin
                w_is_push = 1'b0;
            end
        endcase
    end

    assign w_req  = w_is_byte ? TAKE_W'(LANES) : TAKE_W'(1);
    assign w_room = DEPTH_CNT - r_count;

    // room and fill are clipped to the request, which is at most 8
    assign w_n_push = (w_room  >= CNT_W'(w_req)) ? w_req : TAKE_W'(w_room);
    assign w_taken  = (r_count >= CNT_W'(w_req)) ? w_req : TAKE_W'(r_count);

    // serialization order: bit j of the stream goes to position wp + j
    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            if (w_is_byte) begin
                w_ser[j] = r_msb ? i_in_data.data_in[LANES - 1 - j]
                                 : i_in_data.data_in[j];
            end else begin
                w_ser[j] = (j == 0) ? (|i_in_data.data_in) : 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // bank address mapping
    // ------------------------------------------------------------------
    always_comb begin
        logic [POS_W-1:0]  base;
        logic [LANE_W-1:0] off;
        logic [POS_W-1:0]  pos;
        base = w_is_push ? r_wp : r_rp;
        for (int k = 0; k < LANES; k++) begin
            // stream index that lands in bank k
            off        = LANE_W'(k) - base[LANE_W-1:0];
            pos        = base + POS_W'(off);
            w_addr[k]  = pos[POS_W-1:LANE_W];
            w_we[k]    = w_accept && w_is_push && (TAKE_W'(off) < w_n_push);
            w_wdata[k] = w_ser[off];
        end
    end

    for (genvar k = 0; k < LANES; k++) begin : g_bank
        bfg_bank_ram u_bank (
            .i_clk   (i_clk),
            .i_addr  (w_addr[k]),
            .i_we    (w_we[k]),
            .i_wdata (w_wdata[k]),
            .o_rdata (w_rdata[k])
        );
    end

    bfg_bit_gather u_gather (
        .i_rdata (w_rdata),
        .i_ctx   (r_ctx),
        .o_value (w_gather)
    );

    // ------------------------------------------------------------------
    // next positions, count and result
    // ------------------------------------------------------------------
    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        n_ctx   = r_ctx;
        n_out   = r_out;

        if (w_load_gather) begin
            // pop result, loaded in the cycle after the bank read
            n_out.data_out  = w_gather;
            n_out.bits_held = HELD_W'(r_count);
            n_out.overflow  = 1'b0;
            n_out.underrun  = r_ctx.underrun;
        end else if (w_accept) begin
            n_out.data_out = '0;
            n_out.overflow = 1'b0;
            n_out.underrun = 1'b0;
            if (w_is_push) begin
                n_wp           = r_wp + POS_W'(w_n_push);
                n_count        = r_count + CNT_W'(w_n_push);
                n_out.overflow = (w_n_push != w_req);
            end else if (w_is_pop) begin
                n_rp              = r_rp + POS_W'(w_taken);
                n_count           = r_count - CNT_W'(w_taken);
                n_ctx.offset      = r_rp[LANE_W-1:0];
                n_ctx.taken       = w_taken;
                n_ctx.msb_first   = r_msb;
                n_ctx.is_byte     = w_is_byte;
                n_ctx.underrun    = (w_taken != w_req);
            end else if (i_in_data.mode == MODE_CLEAR) begin
                n_wp    = '0;
                n_rp    = '0;
                n_count = '0;
            end
            n_out.bits_held = HELD_W'(n_count);
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wp        <= '0;
            r_rp        <= '0;
            r_count     <= '0;
            r_msb       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
            if (i_cfg_valid) begin
                r_msb <= i_cfg_data;
            end
            // a pop leaves the result slot empty until its gather cycle
            if (w_load_gather || (w_accept && !w_is_pop)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_ctx <= n_ctx;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: design/bfg_bank_ram.sv
// ----------------------------------------------------------------------------
// bfg_bank_ram
// one bit-wide bank of the store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bfg_bank_ram
    import bfg_pkg::*;
(
    input  logic             i_clk,
    input  logic [ROW_W-1:0] i_addr,
    input  logic             i_we,
    input  logic             i_wdata,
    output logic             o_rdata
);

    logic r_mem [ROWS];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/bfg_bit_gather.sv
// ----------------------------------------------------------------------------
// bfg_bit_gather
// orders the bits read from the eight banks into the popped bit or byte
// ----------------------------------------------------------------------------
module bfg_bit_gather
    import bfg_pkg::*;
(
    input  logic [LANES-1:0] i_rdata,
    input  t_pop_ctx         i_ctx,
    output logic [7:0]       o_value
);

    always_comb begin
        logic [LANE_W-1:0] lane;
        logic [LANE_W-1:0] slot;
        o_value = '0;
        for (int j = 0; j < LANES; j++) begin
            lane = i_ctx.offset + LANE_W'(j);
            slot = i_ctx.msb_first ? LANE_W'(LANES - 1 - j) : LANE_W'(j);
            if (TAKE_W'(j) < i_ctx.taken) begin
                if (i_ctx.is_byte) begin
                    o_value[slot] = i_rdata[lane];
                end else if (j == 0) begin
                    o_value[0] = i_rdata[lane];
                end
            end
        end
    end

endmodule
